[rtl/core/stochastic_fast_k_unit_assert.svh]
// Assertion macros for the stochastic fast %K unit.
`ifndef STOCHASTIC_FAST_K_UNIT_ASSERT_SVH
`define STOCHASTIC_FAST_K_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SFK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// Condition in one cycle implies a condition in the next.
`define SFK_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define SFK_ASSERT(label, prop, msg)
`define SFK_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

[rtl/core/sfk_pkg.sv]
// Shared constants, types and sequencer states of the stochastic fast %K unit.
package sfk_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int PRICE_BITS_DEF = 32;

	localparam int FRAC_BITS = 16;
	localparam int INT_BITS  = 7;                    // quotient integer bits, 100 < 2^7
	localparam int QUOT_W    = INT_BITS + FRAC_BITS;
	localparam int FASTK_W   = 23;
	localparam int OUT_W     = ((FASTK_W + 7) / 8) * 8;
	localparam int KPERIOD_W = 7;

	localparam logic [KPERIOD_W-1:0] KPERIOD_RST = KPERIOD_W'(5);
	localparam logic [INT_BITS-1:0]  HUNDRED     = INT_BITS'(100);
	localparam logic [FASTK_W-1:0]   FULL_SCALE  = FASTK_W'(100 << FRAC_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_PREP,
		ST_CHECK,
		ST_DIV,
		ST_EMIT
	} sfk_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[rtl/core/sfk_window.sv]
// Circular high/low price window: one write port, one registered read port.
module sfk_window #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_high,
	input  logic [WIDTH-1:0] wr_low,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_high,
	output logic [WIDTH-1:0] rd_low
);

	logic [WIDTH-1:0] high_mem [DEPTH];
	logic [WIDTH-1:0] low_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			high_mem[wr_addr] <= wr_high;
			low_mem[wr_addr]  <= wr_low;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_high <= high_mem[rd_addr];
			rd_low  <= low_mem[rd_addr];
		end
	end

endmodule

[rtl/core/sfk_div.sv]
// Restoring divider, one quotient bit per cycle, for 100*num/den in fixed point.
module sfk_div
	import sfk_pkg::*;
#(
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [PRICE_BITS+INT_BITS-1:0] dividend,  // 100*num, num < den
	input  logic [PRICE_BITS-1:0]          divisor,
	output logic [QUOT_W-1:0]              quotient,
	output div_status_t                    status
);

	localparam int CW = $clog2(QUOT_W + 1);

	logic [PRICE_BITS-1:0] rem_q;
	logic [PRICE_BITS-1:0] den_q;
	logic [QUOT_W-1:0]     sh_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [PRICE_BITS:0]   trial;
	logic [PRICE_BITS:0]   diff;
	logic                  ge;

	assign trial = {rem_q, sh_q[QUOT_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// top bits of the dividend are already below the divisor; the rest shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PRICE_BITS+INT_BITS-1:INT_BITS];
			sh_q  <= {dividend[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[PRICE_BITS-1:0] : trial[PRICE_BITS-1:0];
			sh_q   <= {sh_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient    = quot_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

[rtl/core/stochastic_fast_k_unit.sv]
// Top level of the stochastic fast %K unit: sequencer, window scan and result register.
//
// Channel  Dir  Handshake             Contents
// s_*      in   s_tvalid / s_tready   one price bar (high, low, close) + restart in tuser
// m_*      out  m_tvalid / m_tready   raw %K in Q7.16 + flat-range flag in tuser
// cfg_*    in   cfg_we (no wait)      k_period, window length in bars
//
// Sequence: a bar that leaves fewer than k bars stored is only written and the unit stays
// ready. A bar with a result passes accept, k reads, the registered read, prep, check, emit,
// with the divide (23 quotient bits plus a done step) between check and emit; k = eff. period.
// Reset clears sequencer, fill count, write pointer and k_period (to 5); the window
// memory is not cleared, the fill count keeps unwritten entries unread.
// A waiting result holds the sequencer in emit; no new bar is taken meanwhile.
module stochastic_fast_k_unit
	import sfk_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input bars
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [((3*PRICE_BITS+7)/8)*8-1:0] s_tdata, // high_price, low_price, close_price
	input  logic [0:0]             s_tuser,  // restart
	// results
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_W-1:0]       m_tdata,  // fast_k
	output logic [0:0]             m_tuser,  // flat_range
	// configuration
	input  logic                   cfg_we,
	input  logic [KPERIOD_W-1:0]   cfg_wdata // k_period
);

	`include "stochastic_fast_k_unit_assert.svh"

	localparam int AW   = $clog2(WINDOW_MAX);
	localparam int KW   = $clog2(WINDOW_MAX + 1);
	localparam int CMPW = (KW > KPERIOD_W) ? KW : KPERIOD_W;
	localparam int DW   = PRICE_BITS + INT_BITS;

	sfk_state_t state_q, state_d;

	logic [KPERIOD_W-1:0]  kperiod_q;
	logic [AW-1:0]         wpos_q;
	logic [KW-1:0]         fill_q;
	logic [KW-1:0]         k_q;
	logic [KW-1:0]         cnt_q;
	logic [AW-1:0]         rd_q;
	logic [PRICE_BITS-1:0] close_q;
	logic [PRICE_BITS-1:0] hi_q;
	logic [PRICE_BITS-1:0] lo_q;
	logic                  first_q;
	logic                  rd_valid_s1;
	logic [PRICE_BITS-1:0] num_q;
	logic [PRICE_BITS-1:0] den_q;
	logic                  zero_q;
	logic                  flat_q;
	logic [FASTK_W-1:0]    res_q;
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;
	logic                  m_tuser_q;

	logic                  accept;
	logic [PRICE_BITS-1:0] in_high;
	logic [PRICE_BITS-1:0] in_low;
	logic [PRICE_BITS-1:0] in_close;
	logic                  in_restart;
	logic [AW-1:0]         wr_idx;
	logic [KW-1:0]         fill_base;
	logic [KW-1:0]         fill_new;
	logic [KW-1:0]         k_eff;
	logic                  go_scan;
	logic                  rd_en;
	logic [PRICE_BITS-1:0] rd_high;
	logic [PRICE_BITS-1:0] rd_low;
	logic                  range_pos;
	logic                  range_flat;
	logic                  full_ratio;
	logic                  div_start;
	logic [DW-1:0]         dividend;
	logic [QUOT_W-1:0]     quotient;
	div_status_t           div_st;
	logic                  out_free;

	assign in_high    = s_tdata[PRICE_BITS-1:0];
	assign in_low     = s_tdata[2*PRICE_BITS-1:PRICE_BITS];
	assign in_close   = s_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
	assign in_restart = s_tuser[0];
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;

	// period clamp: 0 acts as 1, beyond the window depth acts as the depth
	always_comb begin
		if (kperiod_q == '0) begin
			k_eff = KW'(1);
		end else if (CMPW'(kperiod_q) > CMPW'(WINDOW_MAX)) begin
			k_eff = KW'(WINDOW_MAX);
		end else begin
			k_eff = KW'(kperiod_q);
		end
	end

	// bar intake: restart empties the window before this bar is stored
	assign wr_idx    = in_restart ? '0 : wpos_q;
	assign fill_base = in_restart ? '0 : fill_q;
	assign fill_new  = (fill_base < KW'(WINDOW_MAX)) ? fill_base + KW'(1) : fill_base;
	assign go_scan   = fill_new >= k_eff;

	// range analysis on the scanned extremes
	assign range_pos  = hi_q > lo_q;
	assign range_flat = hi_q == lo_q;
	assign full_ratio = num_q >= den_q;
	assign dividend   = DW'(num_q) * DW'(HUNDRED);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && go_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == k_q - KW'(1)) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_d = ST_PREP;
			ST_PREP:     state_d = ST_CHECK;
			ST_CHECK: begin
				if (zero_q || full_ratio) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_st.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready  = 1'b1;
			ST_SCAN:  rd_en     = 1'b1;
			ST_CHECK: div_start = !zero_q && !full_ratio;
			ST_SCAN_END, ST_PREP, ST_DIV, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kperiod_q   <= KPERIOD_RST;
			wpos_q      <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			first_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			if (cfg_we) begin
				kperiod_q <= cfg_wdata;
			end
			if (accept) begin
				wpos_q  <= (wr_idx == AW'(WINDOW_MAX - 1)) ? '0 : wr_idx + AW'(1);
				fill_q  <= fill_new;
				cnt_q   <= '0;
				first_q <= 1'b1;
			end else begin
				if (rd_en) begin
					cnt_q <= cnt_q + KW'(1);
				end
				if (rd_valid_s1) begin
					first_q <= 1'b0;
				end
			end
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath: newest entry first, walking back through the ring
	always_ff @(posedge clk) begin
		if (accept) begin
			close_q <= in_close;
			k_q     <= k_eff;
			rd_q    <= wr_idx;
		end else if (rd_en) begin
			rd_q <= (rd_q == '0) ? AW'(WINDOW_MAX - 1) : rd_q - AW'(1);
		end
		if (rd_valid_s1) begin
			if (first_q || rd_high > hi_q) begin
				hi_q <= rd_high;
			end
			if (first_q || rd_low < lo_q) begin
				lo_q <= rd_low;
			end
		end
		if (state_q == ST_PREP) begin
			flat_q <= range_flat;
			if (range_pos) begin
				den_q  <= hi_q - lo_q;
				num_q  <= close_q - lo_q;
				zero_q <= close_q <= lo_q;
			end else begin
				// inverted range counts a close below lowest as positive
				den_q  <= lo_q - hi_q;
				num_q  <= lo_q - close_q;
				zero_q <= range_flat || close_q >= lo_q;
			end
		end
		if (state_q == ST_CHECK) begin
			res_q <= zero_q ? '0 : FULL_SCALE;
		end
		if (state_q == ST_DIV && div_st.done) begin
			res_q <= FASTK_W'(quotient);
		end
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= OUT_W'(res_q);
			m_tuser_q <= flat_q;
		end
	end

	sfk_window #(
		.DEPTH (WINDOW_MAX),
		.WIDTH (PRICE_BITS),
		.AW    (AW)
	) u_window (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (wr_idx),
		.wr_high (in_high),
		.wr_low  (in_low),
		.rd_en   (rd_en),
		.rd_addr (rd_q),
		.rd_high (rd_high),
		.rd_low  (rd_low)
	);

	sfk_div #(
		.PRICE_BITS (PRICE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den_q),
		.quotient (quotient),
		.status   (div_st)
	);

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	`SFK_ASSERT(a_fill_bound, fill_q <= KW'(WINDOW_MAX), "fill count beyond window depth")
	`SFK_ASSERT(a_flat_zero, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0), "flat range with nonzero fast K")
	`SFK_ASSERT(a_fastk_scale, m_tvalid |-> (m_tdata <= OUT_W'(FULL_SCALE)), "fast K above full scale")
	`SFK_ASSERT(a_div_owned, div_st.busy |-> (state_q == ST_DIV), "divider busy outside divide state")
	`SFK_ASSERT_NEXT(a_scan_follows, accept && go_scan, state_q == ST_SCAN, "full window did not start scan")

endmodule
